### hdl/psa_pkg.sv
package psa_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SKIP = 2'd1,
        PH_HEAD = 2'd2,
        PH_BODY = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SYNTAX  = 3'd1,
        ST_VERSION = 3'd2,
        ST_GAP     = 3'd3,
        ST_UNEXP   = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] section_byte;
        logic       byte_valid;
        logic       section_end;
        logic       table_end;
        t_status    status;
    } t_result;

    localparam logic [7:0]  STUFF_ID     = 8'hFF;
    localparam logic [7:0]  SYNTAX_MASK  = 8'hC0;
    localparam logic [7:0]  SYNTAX_VALUE = 8'h80;
    localparam logic [11:0] MIN_LEN      = 12'd5;
    localparam logic [12:0] HDR_BYTES    = 13'd3;

    // Byte positions within a section
    localparam logic [12:0] POS_TABLE_ID = 13'd0;
    localparam logic [12:0] POS_LEN_HI   = 13'd1;
    localparam logic [12:0] POS_LEN_LO   = 13'd2;
    localparam logic [12:0] POS_VERSION  = 13'd5;
    localparam logic [12:0] POS_SECTION  = 13'd6;
    localparam logic [12:0] POS_LAST     = 13'd7;

endpackage

### hdl/psa_core.sv
module psa_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_unit_start,
    output logic              o_res_valid,
    output psa_pkg::t_result  o_res
);
    import psa_pkg::*;

    t_phase      r_phase,           n_phase;
    logic [7:0]  r_skip_left,       n_skip_left;
    logic [12:0] r_byte_count,      n_byte_count;
    logic [11:0] r_section_len,     n_section_len;
    logic [4:0]  r_table_version,   n_table_version;
    logic [7:0]  r_section_index,   n_section_index;
    logic [7:0]  r_last_index,      n_last_index;
    logic [4:0]  r_pending_version, n_pending_version;
    logic [7:0]  r_pending_index,   n_pending_index;
    logic        r_section_done,    n_section_done;
    logic        r_table_done,      n_table_done;

    logic        has_res;
    t_result     res;
    t_status     st;
    logic [7:0]  skip_dec;
    logic [11:0] len_full;
    logic        te;

    always_comb begin
        n_phase           = r_phase;
        n_skip_left       = r_skip_left;
        n_byte_count      = r_byte_count;
        n_section_len     = r_section_len;
        n_table_version   = r_table_version;
        n_section_index   = r_section_index;
        n_last_index      = r_last_index;
        n_pending_version = r_pending_version;
        n_pending_index   = r_pending_index;
        n_section_done    = r_section_done;
        n_table_done      = r_table_done;
        has_res           = 1'b0;
        res               = '0;
        st                = ST_OK;
        skip_dec          = r_skip_left - 8'd1;
        len_full          = r_section_len | {4'd0, i_data_byte};
        te                = 1'b0;

        if (i_unit_start) begin
            // Pointer byte: restart section framing, report a cut-off section
            n_byte_count = '0;
            n_skip_left  = i_data_byte;
            n_phase      = (i_data_byte != 8'd0) ? PH_SKIP : PH_HEAD;
            if ((r_phase == PH_HEAD && r_byte_count != 13'd0) || r_phase == PH_BODY) begin
                has_res    = 1'b1;
                res.status = ST_UNEXP;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_SKIP: begin
                    n_skip_left = skip_dec;
                    if (skip_dec == 8'd0) begin
                        n_phase = PH_HEAD;
                    end
                end
                default: begin
                    if (r_byte_count == POS_TABLE_ID && i_data_byte == STUFF_ID) begin
                        n_phase = PH_IDLE;
                    end else begin
                        if (r_byte_count == POS_LEN_HI) begin
                            if ((i_data_byte & SYNTAX_MASK) != SYNTAX_VALUE) begin
                                st = ST_SYNTAX;
                            end
                            n_section_len = {i_data_byte[3:0], 8'd0};
                        end else if (r_byte_count == POS_LEN_LO) begin
                            n_section_len = len_full;
                            if (len_full < MIN_LEN) begin
                                st = ST_SYNTAX;
                            end
                        end else if (r_byte_count == POS_VERSION) begin
                            n_pending_version = i_data_byte[5:1];
                        end else if (r_byte_count == POS_SECTION) begin
                            n_pending_index = i_data_byte;
                        end else if (r_byte_count == POS_LAST) begin
                            // Judge the section against the table in progress
                            if (r_table_done || r_pending_index == 8'd0) begin
                                n_table_done    = 1'b0;
                                n_table_version = r_pending_version;
                                n_section_index = r_pending_index;
                                n_last_index    = i_data_byte;
                            end else if (r_section_done) begin
                                if (r_table_version != r_pending_version) begin
                                    st = ST_VERSION;
                                end else if (r_section_index + 8'd1 != r_pending_index) begin
                                    st = ST_GAP;
                                end else begin
                                    n_section_index = r_pending_index;
                                end
                            end else begin
                                st = ST_UNEXP;
                            end
                            n_section_done = 1'b0;
                        end

                        has_res          = 1'b1;
                        res.section_byte = i_data_byte;
                        if (st != ST_OK) begin
                            // Drop the rest of the section until the next unit start
                            n_phase      = PH_IDLE;
                            n_byte_count = '0;
                            res.status   = st;
                        end else begin
                            res.byte_valid = 1'b1;
                            n_byte_count   = r_byte_count + 13'd1;
                            if (r_byte_count >= POS_LAST) begin
                                n_phase = PH_BODY;
                                if (r_byte_count + 13'd1 == HDR_BYTES + {1'b0, r_section_len}) begin
                                    te              = (n_section_index == n_last_index);
                                    n_section_done  = 1'b1;
                                    n_table_done    = n_table_done | te;
                                    n_phase         = PH_HEAD;
                                    n_byte_count    = '0;
                                    res.section_end = 1'b1;
                                    res.table_end   = te;
                                end
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_skip_left       <= '0;
            r_byte_count      <= '0;
            r_section_len     <= '0;
            r_table_version   <= '0;
            r_section_index   <= '0;
            r_last_index      <= '0;
            r_pending_version <= '0;
            r_pending_index   <= '0;
            r_section_done    <= 1'b0;
            r_table_done      <= 1'b1;
        end else if (i_accept) begin
            r_phase           <= n_phase;
            r_skip_left       <= n_skip_left;
            r_byte_count      <= n_byte_count;
            r_section_len     <= n_section_len;
            r_table_version   <= n_table_version;
            r_section_index   <= n_section_index;
            r_last_index      <= n_last_index;
            r_pending_version <= n_pending_version;
            r_pending_index   <= n_pending_index;
            r_section_done    <= n_section_done;
            r_table_done      <= n_table_done;
        end
    end

    assign o_res_valid = i_accept & has_res;
    assign o_res       = res;

endmodule

### hdl/psa_out_reg.sv
module psa_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  psa_pkg::t_result  i_res,
    input  logic              i_stall,
    output logic              o_busy,
    output logic              o_valid,
    output psa_pkg::t_result  o_res
);
    import psa_pkg::*;

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_load;
        end
    end

    // Hold the payload while the receiver stalls
    always_ff @(posedge i_clk) begin
        if ((!r_valid || !i_stall) && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_busy  = r_valid & i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### hdl/psi_section_assembler.sv
// PSI section assembler.
// Input channel: one transport packet payload byte per transfer on
// i_data_byte, with i_unit_start high on the pointer byte of a packet that
// starts a unit. A transfer happens when i_valid is high and o_stall is low.
// Output channel: zero or one result per input transfer, carrying the
// section byte with byte_valid, section_end, table_end and a status code.
// A transfer happens when o_valid is high and i_stall is low.
// A result appears on the output in the cycle after the input byte that
// caused it is taken. One byte is taken per cycle while o_stall is low; the
// section state is updated in the same cycle a byte is taken.
// Skipped bytes, stuffing, bytes outside a section and pointer bytes that
// cut off no section give no result. o_stall rises only while a result is
// held and the receiver stalls, so bytes stop for exactly as long as it waits.
// Reset (i_rst_n low, synchronous) empties the output register and returns
// the block to waiting for a unit start, with no table in progress.
module psi_section_assembler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_unit_start,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_section_byte,
    output logic       o_byte_valid,
    output logic       o_section_end,
    output logic       o_table_end,
    output logic [2:0] o_status
);
    import psa_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    busy;

    assign accept  = i_valid & ~busy;
    assign o_stall = busy;

    psa_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_unit_start (i_unit_start),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    psa_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_section_byte = out_res.section_byte;
    assign o_byte_valid   = out_res.byte_valid;
    assign o_section_end  = out_res.section_end;
    assign o_table_end    = out_res.table_end;
    assign o_status       = out_res.status;

endmodule

### dv/psi_section_assembler_tb.sv
`timescale 1ns / 100ps

module psi_section_assembler_tb;
    import psa_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RANDOM_ITEMS = 650;
    localparam int IDLE_LIMIT   = 1000;
    localparam int HOLD_CYCLES  = 120;
    localparam int HOLD_AFTER   = 100;
    localparam int N_DIRECTED   = 27;

    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_NONE,
        ROW_GIVEN
    } t_check;

    typedef struct packed {
        logic [7:0] db;
        logic       us;
        t_check     mode;
        t_result    given;
    } t_row;

    typedef enum logic [2:0] {
        FLAW_NONE,
        FLAW_SYNTAX,
        FLAW_SHORT,
        FLAW_VERSION,
        FLAW_GAP,
        FLAW_CUT
    } t_flaw;

    localparam t_result NO_RES = '0;

    localparam t_row DIRECTED_ROWS [N_DIRECTED] = '{
        // pointer 0, then a one-section-of-two table start
        '{8'h00, 1'b1, ROW_NONE,  NO_RES},
        '{8'h00, 1'b0, ROW_GIVEN, '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK}},
        '{8'hB0, 1'b0, ROW_GIVEN, '{8'hB0, 1'b1, 1'b0, 1'b0, ST_OK}},
        '{8'h05, 1'b0, ROW_GIVEN, '{8'h05, 1'b1, 1'b0, 1'b0, ST_OK}},
        '{8'h12, 1'b0, ROW_MODEL, NO_RES},
        '{8'h34, 1'b0, ROW_MODEL, NO_RES},
        '{8'hC3, 1'b0, ROW_GIVEN, '{8'hC3, 1'b1, 1'b0, 1'b0, ST_OK}},
        '{8'h00, 1'b0, ROW_GIVEN, '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK}},
        '{8'h01, 1'b0, ROW_GIVEN, '{8'h01, 1'b1, 1'b1, 1'b0, ST_OK}},
        // back-to-back section with a changed version
        '{8'h00, 1'b0, ROW_GIVEN, '{8'h00, 1'b1, 1'b0, 1'b0, ST_OK}},
        '{8'hB0, 1'b0, ROW_GIVEN, '{8'hB0, 1'b1, 1'b0, 1'b0, ST_OK}},
        '{8'h05, 1'b0, ROW_GIVEN, '{8'h05, 1'b1, 1'b0, 1'b0, ST_OK}},
        '{8'hFF, 1'b0, ROW_MODEL, NO_RES},
        '{8'h00, 1'b0, ROW_MODEL, NO_RES},
        '{8'hC5, 1'b0, ROW_GIVEN, '{8'hC5, 1'b1, 1'b0, 1'b0, ST_OK}},
        '{8'h01, 1'b0, ROW_GIVEN, '{8'h01, 1'b1, 1'b0, 1'b0, ST_OK}},
        '{8'h01, 1'b0, ROW_GIVEN, '{8'h01, 1'b0, 1'b0, 1'b0, ST_VERSION}},
        // pointer skip, stuffing, idle byte
        '{8'h01, 1'b1, ROW_NONE,  NO_RES},
        '{8'hEE, 1'b0, ROW_NONE,  NO_RES},
        '{8'hFF, 1'b0, ROW_NONE,  NO_RES},
        '{8'h77, 1'b0, ROW_NONE,  NO_RES},
        // bad syntax bits
        '{8'h00, 1'b1, ROW_NONE,  NO_RES},
        '{8'h02, 1'b0, ROW_GIVEN, '{8'h02, 1'b1, 1'b0, 1'b0, ST_OK}},
        '{8'h40, 1'b0, ROW_GIVEN, '{8'h40, 1'b0, 1'b0, 1'b0, ST_SYNTAX}},
        // section cut off by a new unit start
        '{8'h00, 1'b1, ROW_NONE,  NO_RES},
        '{8'h02, 1'b0, ROW_GIVEN, '{8'h02, 1'b1, 1'b0, 1'b0, ST_OK}},
        '{8'h00, 1'b1, ROW_GIVEN, '{8'h00, 1'b0, 1'b0, 1'b0, ST_UNEXP}}
    };

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_data_byte  = 8'h00;
    logic       i_unit_start = 1'b0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_section_byte;
    logic       o_byte_valid;
    logic       o_section_end;
    logic       o_table_end;
    logic [2:0] o_status;

    t_check  row_mode  = ROW_NONE;
    t_result row_given = '0;

    t_row    payload_q [$];
    t_result assembled_q [$];
    int      err_cnt = 0;
    int      idle_cycles = 0;

    // Parser state mirrored from the block
    t_phase      ps_phase = PH_IDLE;
    logic [7:0]  ps_skip  = '0;
    logic [12:0] ps_count = '0;
    logic [11:0] ps_len   = '0;
    logic [4:0]  ps_tver  = '0;
    logic [7:0]  ps_sidx  = '0;
    logic [7:0]  ps_lidx  = '0;
    logic [4:0]  ps_pver  = '0;
    logic [7:0]  ps_pidx  = '0;
    logic        ps_sdone = 1'b0;
    logic        ps_tdone = 1'b1;

    psi_section_assembler uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_unit_start   (i_unit_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_section_byte (o_section_byte),
        .o_byte_valid   (o_byte_valid),
        .o_section_end  (o_section_end),
        .o_table_end    (o_table_end),
        .o_status       (o_status)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_status judge_header(input logic [7:0] last_byte);
        t_status st;
        st = ST_OK;
        if (ps_tdone || ps_pidx == 8'd0) begin
            ps_tdone = 1'b0;
            ps_tver  = ps_pver;
            ps_sidx  = ps_pidx;
            ps_lidx  = last_byte;
        end else if (ps_sdone) begin
            if (ps_tver != ps_pver)
                st = ST_VERSION;
            else if (8'(ps_sidx + 8'd1) != ps_pidx)
                st = ST_GAP;
            else
                ps_sidx = ps_pidx;
        end else begin
            st = ST_UNEXP;
        end
        ps_sdone = 1'b0;
        return st;
    endfunction

    // Advance the parser by one payload byte; returns 1 when a result is due.
    function automatic bit assemble_byte(input logic [7:0] db, input logic us,
                                         output t_result res);
        logic [12:0] bc;
        t_status     st;
        bit          cut;
        res = '0;
        st  = ST_OK;
        if (us) begin
            cut = (ps_phase == PH_HEAD && ps_count != 13'd0) || ps_phase == PH_BODY;
            ps_count = '0;
            ps_skip  = db;
            ps_phase = (db != 8'd0) ? PH_SKIP : PH_HEAD;
            if (cut)
                res.status = ST_UNEXP;
            return cut;
        end
        if (ps_phase == PH_IDLE)
            return 1'b0;
        if (ps_phase == PH_SKIP) begin
            ps_skip = ps_skip - 8'd1;
            if (ps_skip == 8'd0)
                ps_phase = PH_HEAD;
            return 1'b0;
        end
        bc = ps_count;
        if (bc == POS_TABLE_ID && db == STUFF_ID) begin
            ps_phase = PH_IDLE;
            return 1'b0;
        end
        case (bc)
            POS_LEN_HI: begin
                if ((db & SYNTAX_MASK) != SYNTAX_VALUE)
                    st = ST_SYNTAX;
                ps_len = {db[3:0], 8'h00};
            end
            POS_LEN_LO: begin
                ps_len = ps_len | {4'h0, db};
                if (ps_len < MIN_LEN)
                    st = ST_SYNTAX;
            end
            POS_VERSION: ps_pver = db[5:1];
            POS_SECTION: ps_pidx = db;
            POS_LAST:    st = judge_header(db);
            default: ;
        endcase
        if (st != ST_OK) begin
            ps_phase = PH_IDLE;
            ps_count = '0;
            res = '{db, 1'b0, 1'b0, 1'b0, st};
            return 1'b1;
        end
        ps_count = bc + 13'd1;
        res = '{db, 1'b1, 1'b0, 1'b0, ST_OK};
        if (bc >= POS_LAST) begin
            ps_phase = PH_BODY;
            if (bc + 13'd1 == HDR_BYTES + {1'b0, ps_len}) begin
                res.section_end = 1'b1;
                res.table_end   = (ps_sidx == ps_lidx);
                ps_sdone = 1'b1;
                if (ps_sidx == ps_lidx)
                    ps_tdone = 1'b1;
                ps_phase = PH_HEAD;
                ps_count = '0;
            end
        end
        return 1'b1;
    endfunction

    task automatic queue_byte(input logic [7:0] db, input logic us);
        payload_q.push_back('{db, us, ROW_MODEL, NO_RES});
    endtask

    task automatic queue_section(input logic [4:0] ver, input logic [7:0] sec,
                                 input logic [7:0] last, input t_flaw flaw);
        logic [7:0] sect [$];
        logic [1:0] sync;
        int         len;
        int         keep;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 300) : $urandom_range(5, 24);
        if (flaw == FLAW_SHORT)
            len = $urandom_range(0, 4);
        sync = 2'b10;
        if (flaw == FLAW_SYNTAX) begin
            sync = 2'($urandom_range(0, 2));
            if (sync == 2'b10)
                sync = 2'b11;
        end
        sect.push_back(8'($urandom_range(0, 254)));
        sect.push_back({sync, 2'($urandom), 4'(len >> 8)});
        sect.push_back(8'(len));
        sect.push_back(8'($urandom));
        sect.push_back(8'($urandom));
        sect.push_back({2'($urandom), ver, 1'($urandom)});
        sect.push_back(sec);
        sect.push_back(last);
        while (sect.size() < len + 3)
            sect.push_back(8'($urandom));
        keep = (flaw == FLAW_CUT) ? $urandom_range(1, sect.size() - 1) : sect.size();
        for (int i = 0; i < keep; i++)
            queue_byte(sect[i], 1'b0);
    endtask

    // One table: pointer, sections in order with an occasional flaw, trailing noise.
    task automatic queue_table();
        logic [4:0] ver;
        logic [7:0] last;
        logic [7:0] sec;
        logic [7:0] skip;
        int         pick;
        t_flaw      flaw;
        ver  = 5'($urandom);
        last = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        skip = (pick < 70) ? 8'd0 : (pick < 98) ? 8'($urandom_range(1, 4)) : 8'hFF;
        queue_byte(skip, 1'b1);
        for (int i = 0; i < skip; i++)
            queue_byte(8'($urandom), 1'b0);
        for (int s = 0; s <= last && s < 6; s++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)      flaw = FLAW_NONE;
            else if (pick < 84) flaw = FLAW_SYNTAX;
            else if (pick < 87) flaw = FLAW_SHORT;
            else if (pick < 91) flaw = FLAW_VERSION;
            else if (pick < 95) flaw = FLAW_GAP;
            else                flaw = FLAW_CUT;
            sec = 8'(s);
            if (flaw == FLAW_GAP)
                sec = 8'(s + $urandom_range(2, 3));
            queue_section((flaw == FLAW_VERSION) ? ver ^ 5'($urandom_range(1, 31)) : ver,
                          sec, last, flaw);
            if (flaw == FLAW_CUT || $urandom_range(0, 6) == 0)
                queue_byte(8'd0, 1'b1);
        end
        if ($urandom_range(0, 6) == 0) begin
            queue_byte(STUFF_ID, 1'b0);
            repeat ($urandom_range(0, 4)) queue_byte(8'($urandom), 1'b0);
        end
        if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(1, 8))
                queue_byte(8'($urandom), ($urandom_range(0, 5) == 0));
    endtask

    task automatic note_mismatch(input string why, input t_result want, input t_result got);
        err_cnt++;
        if (err_cnt <= 10)
            $display({"mismatch (%s): byte/valid/send/tend/status ",
                      "expected %02h/%b/%b/%b/%0d, got %02h/%b/%b/%b/%0d"},
                     why, want.section_byte, want.byte_valid, want.section_end,
                     want.table_end, want.status, got.section_byte, got.byte_valid,
                     got.section_end, got.table_end, got.status);
    endtask

    always @(posedge i_clk) begin : watch_results
        t_result got;
        t_result want;
        t_result calc;
        bit      calc_has;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_section_byte, o_byte_valid, o_section_end, o_table_end,
                        t_status'(o_status)};
                if (assembled_q.size() == 0) begin
                    note_mismatch("no result pending", NO_RES, got);
                end else begin
                    want = assembled_q.pop_front();
                    if (got !== want)
                        note_mismatch("wrong field", want, got);
                end
            end
            if (i_valid && !o_stall) begin
                calc_has = assemble_byte(i_data_byte, i_unit_start, calc);
                if (row_mode == ROW_GIVEN)
                    assembled_q.push_back(row_given);
                else if (row_mode == ROW_MODEL && calc_has)
                    assembled_q.push_back(calc);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("psi_section_assembler_tb: errors");
                $finish;
            end
        end
    end

    // Receiver: random stall per result, quiet stretches, one long hold-off.
    initial begin : rx_side
        int unsigned wait_cyc;
        int unsigned taken;
        bit          quiet;
        bit          held;
        taken = 0;
        quiet = 1'b0;
        held  = 1'b0;
        forever begin
            if ($urandom_range(0, 39) == 0)
                quiet = !quiet;
            if (!held && taken == HOLD_AFTER) begin
                wait_cyc = HOLD_CYCLES;
                held = 1'b1;
            end else begin
                wait_cyc = quiet ? 0 : $urandom_range(0, 13);
            end
            if (wait_cyc != 0) begin
                i_stall <= 1'b1;
                repeat (wait_cyc) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            taken++;
        end
    end

    initial begin : tx_side
        t_row        row;
        int unsigned gap;
        bit          quiet;
        quiet = 1'b0;
        foreach (DIRECTED_ROWS[i])
            payload_q.push_back(DIRECTED_ROWS[i]);
        while (payload_q.size() < RANDOM_ITEMS)
            queue_table();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (payload_q.size() != 0) begin
            row = payload_q.pop_front();
            if ($urandom_range(0, 39) == 0)
                quiet = !quiet;
            gap = quiet ? 0 : $urandom_range(0, 13);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid      <= 1'b1;
            i_data_byte  <= row.db;
            i_unit_start <= row.us;
            row_mode     <= row.mode;
            row_given    <= row.given;
            // hold the byte until the transfer
            do @(posedge i_clk); while (o_stall);
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (assembled_q.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (assembled_q.size() != 0) begin
            err_cnt++;
            $display("%0d results never arrived", assembled_q.size());
        end
        if (err_cnt == 0)
            $display("psi_section_assembler_tb: clean");
        else
            $display("psi_section_assembler_tb: errors");
        $finish;
    end

endmodule

### files.f
hdl/psa_pkg.sv
hdl/psa_core.sv
hdl/psa_out_reg.sv
hdl/psi_section_assembler.sv
dv/psi_section_assembler_tb.sv
